FILE: hw/rtl/rrmbx_pkg.sv
package rrmbx_pkg;

  // Default sizes of the mailbox storage.
  localparam int SLOTS_DEF     = 16;
  localparam int MSG_WIDTH_DEF = 32;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W = 1;
  localparam int RANK_W   = 4;
  localparam int MSG_W    = 32;
  localparam int STATUS_W = 2;
  localparam int NS_W     = 4;

  // Register port geometry: one 32-bit register, word addressed.
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_NUM_SENDERS = '0;
  localparam logic [NS_W-1:0]      NUM_SENDERS_RST = NS_W'(1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_SEND_OK   = 2'd0,
    ST_SEND_FULL = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Configuration seen by the controller: the registered active count and
  // the write strobe with the count that the write is about to load.
  typedef struct packed {
    logic [NS_W-1:0] active_n;
    logic            wr_en;
    logic [NS_W-1:0] wr_active_n;
  } cfg_t;

endpackage

FILE: hw/rtl/rrmbx_req_if.sv
interface rrmbx_req_if;
  import rrmbx_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [RANK_W-1:0]   sender_rank;
  logic [MSG_W-1:0]    message;

  modport source (output valid, output opcode, output sender_rank, output message,
                  input ready);
  modport sink (input valid, input opcode, input sender_rank, input message,
                output ready);
endinterface

FILE: hw/rtl/rrmbx_rsp_if.sv
interface rrmbx_rsp_if;
  import rrmbx_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [MSG_W-1:0]    delivered_message;
  logic [RANK_W-1:0]   served_rank;

  modport source (output valid, output status, output delivered_message,
                  output served_rank, input ready);
  modport sink (input valid, input status, input delivered_message,
                input served_rank, output ready);
endinterface

FILE: hw/rtl/rrmbx_cfg.sv
module rrmbx_cfg #(
  parameter int SLOTS = rrmbx_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrmbx_pkg::APB_AW-1:0]   paddr,
  input  logic [rrmbx_pkg::APB_DW-1:0]   pwdata,
  output logic [rrmbx_pkg::APB_DW-1:0]   prdata,
  output logic                           pready,
  output rrmbx_pkg::cfg_t                cfg
);
  import rrmbx_pkg::*;

  logic [NS_W-1:0] num_senders;
  logic [NS_W-1:0] active_n;
  logic [NS_W-1:0] wr_n;
  logic            wr_en;
  logic            sel_ns;

  assign sel_ns = (paddr[APB_AW-1:2] == REG_NUM_SENDERS);
  assign wr_en  = psel && penable && pwrite && sel_ns;
  assign pready = 1'b1;

  // A count of zero acts as one; a count above the slot total is clamped.
  always_comb begin
    wr_n = pwdata[NS_W-1:0];
    if (wr_n == '0) begin
      wr_n = NS_W'(1);
    end
    if (int'(wr_n) > SLOTS) begin
      wr_n = NS_W'(SLOTS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_senders <= NUM_SENDERS_RST;
      active_n    <= NUM_SENDERS_RST;
    end else if (wr_en) begin
      num_senders <= pwdata[NS_W-1:0];
      active_n    <= wr_n;
    end
  end

  assign prdata = sel_ns ? APB_DW'(num_senders) : '0;

  assign cfg.active_n    = active_n;
  assign cfg.wr_en       = wr_en;
  assign cfg.wr_active_n = wr_n;

endmodule

FILE: hw/rtl/rrmbx_msg_mem.sv
module rrmbx_msg_mem #(
  parameter int DEPTH = rrmbx_pkg::SLOTS_DEF,
  parameter int WIDTH = rrmbx_pkg::MSG_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/rrmbx_ctrl.sv
module rrmbx_ctrl #(
  parameter int SLOTS     = rrmbx_pkg::SLOTS_DEF,
  parameter int MSG_WIDTH = rrmbx_pkg::MSG_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rrmbx_pkg::cfg_t          cfg,
  rrmbx_req_if.sink                req,
  rrmbx_rsp_if.source              rsp,
  output logic                     mem_we,
  output logic                     mem_re,
  output logic [$clog2(SLOTS)-1:0] mem_addr,
  output logic [MSG_WIDTH-1:0]     mem_wdata,
  input  logic [MSG_WIDTH-1:0]     mem_rdata
);
  import rrmbx_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CW    = (IDX_W + 1 > NS_W) ? IDX_W + 1 : NS_W;

  logic [SLOTS-1:0]  slot_full;
  logic [SLOTS-1:0]  slot_full_next;
  logic [IDX_W-1:0]  last_served;

  logic              p_valid;
  status_e           p_status;
  logic [IDX_W-1:0]  p_idx;

  logic              o_valid;
  status_e           o_status;
  logic [MSG_W-1:0]  o_msg;
  logic [RANK_W-1:0] o_rank;

  logic              accept;
  logic              move;
  logic              is_send;
  logic [CW-1:0]     after_last;
  logic [CW-1:0]     start;
  logic [SLOTS-1:0]  ring_all;
  logic [SLOTS-1:0]  ring_hi;
  logic              hit_hi;
  logic              hit_any;
  logic [IDX_W-1:0]  idx_hi;
  logic [IDX_W-1:0]  idx_any;
  logic [IDX_W-1:0]  pick_idx;
  logic [IDX_W-1:0]  rank_idx;
  logic              rank_ok;
  status_e           pick_status;

  // Round-robin start: the slot after the last one served, wrapping at the
  // active count.
  always_comb begin
    after_last = CW'(last_served) + CW'(1);
    start      = (after_last >= CW'(cfg.active_n)) ? '0 : after_last;
  end

  // Rotating priority encoder: first full slot at or above the start,
  // otherwise the first full slot overall.
  always_comb begin
    hit_hi  = 1'b0;
    hit_any = 1'b0;
    idx_hi  = '0;
    idx_any = '0;
    for (int i = 0; i < SLOTS; i++) begin
      ring_all[i] = slot_full[i] && (i < int'(cfg.active_n));
      ring_hi[i]  = ring_all[i] && (i >= int'(start));
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (ring_hi[i]) begin
        hit_hi = 1'b1;
        idx_hi = IDX_W'(i);
      end
      if (ring_all[i]) begin
        hit_any = 1'b1;
        idx_any = IDX_W'(i);
      end
    end
  end

  assign pick_idx = hit_hi ? idx_hi : idx_any;

  // Decide the outcome of the request at the input.
  assign is_send  = (req.opcode == OP_SEND);
  assign rank_ok  = (req.sender_rank < cfg.active_n);
  assign rank_idx = IDX_W'(req.sender_rank);

  always_comb begin
    if (is_send) begin
      pick_status = (!rank_ok || slot_full[rank_idx]) ? ST_SEND_FULL : ST_SEND_OK;
    end else begin
      pick_status = hit_any ? ST_DELIVERED : ST_EMPTY;
    end
  end

  // Handshake: the read stage drains into the output register.
  assign move      = p_valid && (!o_valid || rsp.ready);
  assign req.ready = !p_valid || move;
  assign accept    = req.valid && req.ready;

  // Message memory access, issued at the accept edge.
  assign mem_we    = accept && is_send && (pick_status == ST_SEND_OK);
  assign mem_re    = accept && (pick_status == ST_DELIVERED);
  assign mem_addr  = is_send ? rank_idx : pick_idx;
  assign mem_wdata = MSG_WIDTH'(req.message);

  // Full flags: set on an accepted send, cleared on a delivery.
  always_comb begin
    slot_full_next = slot_full;
    if (mem_we) begin
      slot_full_next[rank_idx] = 1'b1;
    end
    if (mem_re) begin
      slot_full_next[pick_idx] = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full   <= '0;
      last_served <= IDX_W'(NUM_SENDERS_RST - NS_W'(1));
      p_valid     <= 1'b0;
      o_valid     <= 1'b0;
    end else begin
      slot_full <= slot_full_next;
      if (cfg.wr_en) begin
        last_served <= IDX_W'(cfg.wr_active_n - NS_W'(1));
      end else if (mem_re) begin
        last_served <= pick_idx;
      end
      if (accept) begin
        p_valid <= 1'b1;
      end else if (move) begin
        p_valid <= 1'b0;
      end
      if (move) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload of the read stage and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_status <= pick_status;
      p_idx    <= pick_idx;
    end
    if (move) begin
      o_status <= p_status;
      if (p_status == ST_DELIVERED) begin
        o_msg  <= MSG_W'(mem_rdata);
        o_rank <= RANK_W'(p_idx);
      end else begin
        o_msg  <= '0;
        o_rank <= '0;
      end
    end
  end

  assign rsp.valid             = o_valid;
  assign rsp.status            = o_status;
  assign rsp.delivered_message = o_msg;
  assign rsp.served_rank       = o_rank;

  // A delivered slot is free afterwards.
  a_deliver_frees: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> !slot_full[$past(pick_idx)])
    else $error("delivered slot still marked full");

  // An accepted send leaves its slot full.
  a_send_fills: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> slot_full[$past(rank_idx)])
    else $error("accepted send did not mark its slot full");

  // The single memory port never sees a read and a write together.
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  // The round-robin pointer stays inside the active slots.
  a_last_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(last_served) < int'(cfg.active_n))
    else $error("last served slot outside the active range");

  // Results other than a delivery carry a zero message and rank.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_status != ST_DELIVERED) |-> (o_msg == '0) && (o_rank == '0))
    else $error("non-delivery result with nonzero payload");

endmodule

FILE: hw/rtl/round_robin_mailbox_channel_top.sv
// A request is taken into the read stage, where its message is read from memory, and
// moves on into the output register when it is empty or its result is taken.
// Throughput: one request per cycle while results are taken; the message memory
// has a single port with a registered read, which sets that rate.
// Reset (synchronous, active high): all slots empty, num_senders = 1, last served
// slot 0, no request in flight. Messages are not cleared; no clearing pass runs.
module round_robin_mailbox_channel_top #(
  parameter int SLOTS     = rrmbx_pkg::SLOTS_DEF,
  parameter int MSG_WIDTH = rrmbx_pkg::MSG_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrmbx_pkg::APB_AW-1:0] paddr,
  input  logic [rrmbx_pkg::APB_DW-1:0] pwdata,
  output logic [rrmbx_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  rrmbx_req_if.sink                    req,
  rrmbx_rsp_if.source                  rsp
);
  import rrmbx_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  cfg_t                 cfg;
  logic                 mem_we;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_addr;
  logic [MSG_WIDTH-1:0] mem_wdata;
  logic [MSG_WIDTH-1:0] mem_rdata;

  // Register port.
  rrmbx_cfg #(
    .SLOTS (SLOTS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Full flags, round-robin pick and result registers.
  rrmbx_ctrl #(
    .SLOTS     (SLOTS),
    .MSG_WIDTH (MSG_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Message words, one per slot.
  rrmbx_msg_mem #(
    .DEPTH (SLOTS),
    .WIDTH (MSG_WIDTH)
  ) u_msg_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

FILE: test/rrmbx_checker.sv
`timescale 1ns / 1ps

module rrmbx_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [rrmbx_pkg::APB_AW-1:0] paddr,
  input  logic [rrmbx_pkg::APB_DW-1:0] pwdata,
  rrmbx_req_if                         req,
  rrmbx_rsp_if                         rsp,
  output int                           err_count,
  output int                           pending
);
  import rrmbx_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;

  typedef struct packed {
    status_e           status;
    logic [MSG_W-1:0]  msg;
    logic [RANK_W-1:0] rank;
  } reply_t;

  // Our own copy of the mailbox state and its register.
  logic                 box_full [NUM_SLOTS];
  logic [MSG_W-1:0]     box_msg [NUM_SLOTS];
  logic [RANK_W-1:0]    last_rank;
  logic [NS_W-1:0]      sender_cfg;
  reply_t               reply_q [$];
  int                   mismatches;

  // A count of zero behaves as one, and the count never exceeds the slots.
  function automatic int unsigned senders_in_use();
    int unsigned n;
    n = sender_cfg;
    if (n == 0) n = 1;
    if (n > NUM_SLOTS) n = NUM_SLOTS;
    return n;
  endfunction

  // Applies one request to the mailbox copy and returns the reply it earns.
  function automatic reply_t serve_request(opcode_e op, logic [RANK_W-1:0] rank,
                                           logic [MSG_W-1:0] msg);
    reply_t      r;
    int unsigned n;
    int unsigned idx;
    logic        found;
    n = senders_in_use();
    r.status = ST_SEND_FULL;
    r.msg = '0;
    r.rank = '0;
    found = 1'b0;
    if (op == OP_SEND) begin
      if (rank >= n || box_full[rank]) begin
        r.status = ST_SEND_FULL;
      end else begin
        box_msg[rank] = msg;
        box_full[rank] = 1'b1;
        r.status = ST_SEND_OK;
      end
    end else begin
      // Scan round robin, starting just after the slot served last.
      r.status = ST_EMPTY;
      idx = last_rank;
      for (int k = 0; k < n; k++) begin
        if (!found) begin
          idx = (idx + 1 >= n) ? 0 : idx + 1;
          if (box_full[idx]) begin
            found = 1'b1;
            last_rank = RANK_W'(idx);
            r.msg = box_msg[idx];
            r.rank = RANK_W'(idx);
            box_full[idx] = 1'b0;
            r.status = ST_DELIVERED;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        box_full[s] = 1'b0;
        box_msg[s] = '0;
      end
      sender_cfg = NUM_SENDERS_RST;
      last_rank = RANK_W'(senders_in_use() - 1);
      reply_q.delete();
      mismatches = 0;
    end else begin
      // Compare a taken reply with the oldest prediction.
      if (rsp.valid && rsp.ready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: reply with nothing expected: status %0d msg %h rank %0d",
                     rsp.status, rsp.delivered_message, rsp.served_rank);
        end else begin
          want = reply_q.pop_front();
          if (rsp.status !== want.status || rsp.delivered_message !== want.msg ||
              rsp.served_rank !== want.rank) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: expected status %0d msg %h rank %0d, ",
                        "got status %0d msg %h rank %0d"},
                       want.status, want.msg, want.rank,
                       rsp.status, rsp.delivered_message, rsp.served_rank);
          end
        end
      end
      // Predict the reply of each request that the block takes.
      if (req.valid && req.ready)
        reply_q.push_back(serve_request(opcode_e'(req.opcode), req.sender_rank,
                                        req.message));
      // A write of the sender count also rewinds the round robin.
      if (psel && penable && pwrite && pready &&
          paddr[APB_AW-1:2] == REG_NUM_SENDERS) begin
        sender_cfg = pwdata[NS_W-1:0];
        last_rank = RANK_W'(senders_in_use() - 1);
      end
    end
    err_count <= mismatches;
    pending <= reply_q.size();
  end

endmodule

FILE: test/tb_round_robin_mailbox_channel_top.sv
`timescale 1ns / 1ps

module tb_round_robin_mailbox_channel_top;
  import rrmbx_pkg::*;

  localparam logic [APB_AW-1:0] ADDR_NUM_SENDERS = {REG_NUM_SENDERS, 2'b00};
  // The word after the only register is not mapped.
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED = {~REG_NUM_SENDERS, 2'b00};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int idle_pct = 0;
  int stall_pct = 0;
  int active_senders = 1;
  int error_total;
  int pending_replies;

  rrmbx_req_if req_ch ();
  rrmbx_rsp_if rsp_ch ();

  round_robin_mailbox_channel_top u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  rrmbx_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .err_count (error_total),
    .pending   (pending_replies)
  );

  always #6 clk = ~clk;

  // The consumer side stalls at random.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard limit on the whole run.
  initial begin
    #4800000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one request, waits until it is taken, then idles at random.
  task automatic put_request(opcode_e op, logic [RANK_W-1:0] rank, logic [MSG_W-1:0] msg);
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.sender_rank <= rank;
    req_ch.message <= msg;
    do @(posedge clk); while (!req_ch.ready);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Holds off new requests until every reply has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_replies != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Changes the sender count once the block is idle; upper data bits are noise.
  task automatic set_senders(logic [NS_W-1:0] count);
    drain();
    write_reg(ADDR_NUM_SENDERS, APB_DW'({$urandom, count}));
    active_senders = (count == 0) ? 1 : count;
  endtask

  function automatic logic [MSG_W-1:0] pick_message();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Alternates fill and drain stretches so slots cycle between full and free.
  task automatic run_traffic(int count);
    int  r;
    logic fill;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      fill = ((i / 20) % 2 == 0);
      r = $urandom_range(99);
      if (r < 8)
        put_request(OP_SEND, RANK_W'($urandom_range(15)), pick_message());
      else if (fill ? (r < 75) : (r < 30))
        put_request(OP_SEND, RANK_W'($urandom_range(active_senders - 1)), pick_message());
      else
        put_request(OP_RECV, RANK_W'($urandom_range(15)), $urandom);
    end
  endtask

  initial begin
    logic [NS_W-1:0] phase_cfg [8];
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_SEND;
    req_ch.sender_rank <= '0;
    req_ch.message <= '0;
    phase_cfg = '{4'd15, 4'd1, 4'd0, 4'd7, NS_W'($urandom_range(1, 15)), 4'd15, 4'd2,
                  NS_W'($urandom_range(15))};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single sender after reset: empty receive, full slot, inactive ranks.
    put_request(OP_RECV, 4'd0, 32'h0);
    put_request(OP_SEND, 4'd0, 32'hFFFF_FFFF);
    put_request(OP_SEND, 4'd0, 32'h0000_0001);
    put_request(OP_SEND, 4'd1, 32'h1234_5678);
    put_request(OP_SEND, 4'd15, 32'h8765_4321);
    put_request(OP_RECV, 4'd15, 32'hFFFF_FFFF);
    put_request(OP_RECV, 4'd0, 32'h0);

    // Widest setting: the scan wraps from the top slot to slot zero.
    set_senders(4'd15);
    put_request(OP_SEND, 4'd0, 32'h0);
    put_request(OP_SEND, 4'd14, 32'hFFFF_FFFF);
    put_request(OP_SEND, 4'd7, 32'hA5A5_5A5A);
    put_request(OP_SEND, 4'd15, 32'h5A5A_A5A5);
    put_request(OP_SEND, 4'd14, 32'h0F0F_0F0F);
    put_request(OP_RECV, 4'd0, 32'h0);
    put_request(OP_RECV, 4'd0, 32'h0);

    // Rewriting the count rewinds the round robin but keeps slot contents.
    set_senders(4'd15);
    put_request(OP_SEND, 4'd3, 32'hC0DE_0003);
    drain();
    write_reg(ADDR_UNMAPPED, 32'h0000_0005);
    put_request(OP_RECV, 4'd0, 32'h0);
    put_request(OP_RECV, 4'd0, 32'h0);

    // A count of zero behaves as a single sender.
    set_senders(4'd0);
    put_request(OP_SEND, 4'd0, 32'hDEAD_BEEF);
    put_request(OP_SEND, 4'd1, 32'h0000_0000);
    put_request(OP_RECV, 4'd0, 32'h0);
    put_request(OP_RECV, 4'd0, 32'h0);

    // Random traffic across settings and idle patterns.
    for (int p = 0; p < 8; p++) begin
      set_senders(phase_cfg[p]);
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 49;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 49;
        end
        default: begin
          idle_pct = 12;
          stall_pct = 12;
        end
      endcase
      run_traffic(205);
    end

    // Let every reply come back, then settle.
    idle_pct = 0;
    stall_pct = 0;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 2000 && pending_replies != 0; w++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_total == 0 && pending_replies == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rrmbx_pkg.sv
hw/rtl/rrmbx_req_if.sv
hw/rtl/rrmbx_rsp_if.sv
hw/rtl/rrmbx_cfg.sv
hw/rtl/rrmbx_msg_mem.sv
hw/rtl/rrmbx_ctrl.sv
hw/rtl/round_robin_mailbox_channel_top.sv
test/rrmbx_checker.sv
test/tb_round_robin_mailbox_channel_top.sv
